// ===== rtl/mm3_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MurmurHash3 x64_128 hasher.
// No dependencies; imported by every module of the block.
package mm3_pkg;

  // Mixing constants
  localparam logic [63:0] MIX_C1    = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_C2    = 64'h4cf5ad432745937f;
  localparam logic [63:0] LANE_ADD1 = 64'h0000000052dce729;
  localparam logic [63:0] LANE_ADD2 = 64'h0000000038495ab5;
  localparam logic [63:0] AVAL_M1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] AVAL_M2   = 64'hc4ceb9fe1a85ec53;

  localparam logic [31:0] COUNT_MAX   = 32'hFFFFFFFF;
  localparam logic [4:0]  BLOCK_BYTES = 5'd16;
  localparam logic [4:0]  WORD_BYTES  = 5'd8;

  // Input transaction
  typedef struct packed {
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  byte_count;
    logic        last_block;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [63:0] hash_low;
    logic [63:0] hash_high;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic [63:0] k1;
    logic [63:0] k2;
    logic [4:0]  n;
    logic        mix1;
    logic        mix2;
    logic        body;
    logic        last;
  } cmd_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Multiplier request and response
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } mul_rsp_t;

endpackage

// ===== rtl/mm3_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input transactions, masks tail bytes and classifies them.
// Depends on mm3_pkg; feeds mm3_queue.
module mm3_front import mm3_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     push,
  output cmd_t     push_data
);

  logic       held;
  cmd_t       cmd;
  cmd_t       cmd_next;
  logic       accept;
  logic [4:0] n_clamp;
  logic       full_blk;
  logic [63:0] mask_lo;
  logic [63:0] mask_hi;

  // Handshake: hold one classified transaction until the queue takes it
  assign in_stall  = held && q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = held && !q_stat.full;
  assign push_data = cmd;

  // Classification and tail masking
  always_comb begin
    n_clamp  = (in_data.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : in_data.byte_count;
    full_blk = !in_data.last_block || (n_clamp == BLOCK_BYTES);
    for (int i = 0; i < 8; i++) begin
      mask_lo[8*i +: 8] = {8{5'(i) < n_clamp}};
      mask_hi[8*i +: 8] = {8{(5'(i) + WORD_BYTES) < n_clamp}};
    end
    cmd_next.k1   = full_blk ? in_data.block_low  : (in_data.block_low  & mask_lo);
    cmd_next.k2   = full_blk ? in_data.block_high : (in_data.block_high & mask_hi);
    cmd_next.n    = full_blk ? BLOCK_BYTES : n_clamp;
    cmd_next.mix1 = full_blk || (n_clamp != 5'd0);
    cmd_next.mix2 = full_blk || (n_clamp > WORD_BYTES);
    cmd_next.body = full_blk;
    cmd_next.last = in_data.last_block;
  end

  // Holding register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== rtl/mm3_queue.sv =====
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the back end.
// Depends on mm3_pkg.
module mm3_queue import mm3_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_data,
  input  logic    pop,
  output cmd_t    pop_data,
  output q_stat_t q_stat
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign pop_data     = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/mm3_mul.sv =====
`timescale 1ns / 1ps
// Shared 64x64 multiplier giving the low 64 bits, one 32x32 partial per cycle.
// Depends on mm3_pkg; used by mm3_back.
module mm3_mul import mm3_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_HL = 2'd1;
  localparam logic [1:0] STEP_LH = 2'd2;

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc;
  logic [1:0]  step;
  logic        busy;
  logic        done;
  logic [31:0] x;
  logic [31:0] y;
  logic [63:0] prod;

  // Operand selection for the current partial product
  always_comb begin
    x    = (step == STEP_HL) ? a_r[63:32] : a_r[31:0];
    y    = (step == STEP_LH) ? b_r[63:32] : b_r[31:0];
    prod = 64'(x) * 64'(y);
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = acc;

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= STEP_LL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_LL;
      end else if (busy) begin
        if (step == STEP_LH) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 2'd1;
      end
    end
  end

  // Operands and accumulator; cross terms only touch the upper word
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (busy) begin
      if (step == STEP_LL) begin
        acc <= prod;
      end else begin
        acc[63:32] <= acc[63:32] + prod[31:0];
      end
    end
  end

endmodule

// ===== rtl/mm3_back.sv =====
`timescale 1ns / 1ps
// Back end: sequencer that runs body mix, tail mix and finalization on the lanes.
// Depends on mm3_pkg; drives mm3_mul and pops from mm3_queue.
module mm3_back import mm3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic [31:0] seed,
  input  q_stat_t   q_stat,
  output logic      pop,
  input  cmd_t      pop_data,
  output mul_req_t  mul_req,
  input  mul_rsp_t  mul_rsp,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [21:0] {
    S_IDLE = 22'h000001,
    S_K1A  = 22'h000002,
    S_K1B  = 22'h000004,
    S_K1C  = 22'h000008,
    S_L1A  = 22'h000010,
    S_L1B  = 22'h000020,
    S_K2A  = 22'h000040,
    S_K2B  = 22'h000080,
    S_K2C  = 22'h000100,
    S_L2A  = 22'h000200,
    S_L2B  = 22'h000400,
    S_FINA = 22'h000800,
    S_FINB = 22'h001000,
    S_F1A  = 22'h002000,
    S_F1B  = 22'h004000,
    S_F1C  = 22'h008000,
    S_F2A  = 22'h010000,
    S_F2B  = 22'h020000,
    S_F2C  = 22'h040000,
    S_OUTA = 22'h080000,
    S_OUTB = 22'h100000,
    S_MULW = 22'h200000
  } state_t;

  state_t      state;
  state_t      state_next;
  state_t      ret;
  state_t      ret_next;
  cmd_t        op;
  logic        started;
  logic        started_next;
  logic [63:0] lane1;
  logic [63:0] lane1_next;
  logic [63:0] lane2;
  logic [63:0] lane2_next;
  logic [31:0] tb;
  logic [31:0] tb_next;
  logic [32:0] tb_sum;
  logic [63:0] tb64;
  logic [63:0] r;
  logic [63:0] r_fold;
  logic        emit;
  logic        out_free;

  assign r        = mul_rsp.result;
  assign r_fold   = r ^ (r >> 33);
  assign tb64     = {32'd0, tb};
  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == S_IDLE) && !q_stat.empty;
  assign tb_sum   = {1'b0, (started ? tb : 32'd0)} + {28'd0, pop_data.n};

  // Sequencer
  always_comb begin
    state_next   = state;
    ret_next     = ret;
    started_next = started;
    lane1_next   = lane1;
    lane2_next   = lane2;
    tb_next      = tb;
    emit         = 1'b0;
    mul_req      = '0;
    unique case (state)
      S_IDLE: begin
        if (pop) begin
          if (!started) begin
            lane1_next = {32'd0, seed};
            lane2_next = {32'd0, seed};
          end
          tb_next      = tb_sum[32] ? COUNT_MAX : tb_sum[31:0];
          started_next = 1'b1;
          if (pop_data.mix1) begin
            state_next = S_K1A;
          end else if (pop_data.mix2) begin
            state_next = S_K2A;
          end else begin
            state_next = S_FINA;
          end
        end
      end
      S_K1A: begin
        mul_req    = '{start: 1'b1, a: op.k1, b: MIX_C1};
        ret_next   = S_K1B;
        state_next = S_MULW;
      end
      S_K1B: begin
        mul_req    = '{start: 1'b1, a: {r[32:0], r[63:33]}, b: MIX_C2};
        ret_next   = S_K1C;
        state_next = S_MULW;
      end
      S_K1C: begin
        lane1_next = lane1 ^ r;
        if (op.body) begin
          state_next = S_L1A;
        end else if (op.mix2) begin
          state_next = S_K2A;
        end else if (op.last) begin
          state_next = S_FINA;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_L1A: begin
        lane1_next = {lane1[36:0], lane1[63:37]} + lane2;
        state_next = S_L1B;
      end
      S_L1B: begin
        lane1_next = (lane1 << 2) + lane1 + LANE_ADD1;
        state_next = S_K2A;
      end
      S_K2A: begin
        mul_req    = '{start: 1'b1, a: op.k2, b: MIX_C2};
        ret_next   = S_K2B;
        state_next = S_MULW;
      end
      S_K2B: begin
        mul_req    = '{start: 1'b1, a: {r[30:0], r[63:31]}, b: MIX_C1};
        ret_next   = S_K2C;
        state_next = S_MULW;
      end
      S_K2C: begin
        lane2_next = lane2 ^ r;
        if (op.body) begin
          state_next = S_L2A;
        end else if (op.last) begin
          state_next = S_FINA;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_L2A: begin
        lane2_next = {lane2[32:0], lane2[63:33]} + lane1;
        state_next = S_L2B;
      end
      S_L2B: begin
        lane2_next = (lane2 << 2) + lane2 + LANE_ADD2;
        state_next = op.last ? S_FINA : S_IDLE;
      end
      // Length xor and cross-adds
      S_FINA: begin
        lane1_next = (lane1 ^ tb64) + (lane2 ^ tb64);
        state_next = S_FINB;
      end
      S_FINB: begin
        lane2_next = (lane2 ^ tb64) + lane1;
        state_next = S_F1A;
      end
      // Avalanche on lane one
      S_F1A: begin
        mul_req    = '{start: 1'b1, a: lane1 ^ (lane1 >> 33), b: AVAL_M1};
        ret_next   = S_F1B;
        state_next = S_MULW;
      end
      S_F1B: begin
        mul_req    = '{start: 1'b1, a: r_fold, b: AVAL_M2};
        ret_next   = S_F1C;
        state_next = S_MULW;
      end
      S_F1C: begin
        lane1_next = r_fold;
        state_next = S_F2A;
      end
      // Avalanche on lane two
      S_F2A: begin
        mul_req    = '{start: 1'b1, a: lane2 ^ (lane2 >> 33), b: AVAL_M1};
        ret_next   = S_F2B;
        state_next = S_MULW;
      end
      S_F2B: begin
        mul_req    = '{start: 1'b1, a: r_fold, b: AVAL_M2};
        ret_next   = S_F2C;
        state_next = S_MULW;
      end
      S_F2C: begin
        lane2_next = r_fold;
        state_next = S_OUTA;
      end
      S_OUTA: begin
        lane1_next = lane1 + lane2;
        state_next = S_OUTB;
      end
      S_OUTB: begin
        if (out_free) begin
          emit         = 1'b1;
          started_next = 1'b0;
          state_next   = S_IDLE;
        end
      end
      S_MULW: begin
        if (mul_rsp.done) begin
          state_next = ret;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      ret     <= ret_next;
      started <= started_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lane1 <= lane1_next;
    lane2 <= lane2_next;
    tb    <= tb_next;
    if (pop) begin
      op <= pop_data;
    end
    if (emit) begin
      out_data.hash_low  <= lane1;
      out_data.hash_high <= lane2 + lane1;
    end
  end

endmodule

// ===== rtl/murmur3_x64_128_hasher.sv =====
`timescale 1ns / 1ps
// MurmurHash3 x64_128 hasher, top level: seed register, front, queue, back, multiplier.
// A last item adds finalization to its block's mixing; the back end pops a new command only from its idle state.
// Every 64-bit product runs as a sequence of 32x32 partials on the one shared multiplier (mm3_mul).
// An item passes through the front register and the queue before the back-end work.
// Reset (rst, synchronous): seed 0, queue empty, no message in progress, no result pending.
module murmur3_x64_128_hasher import mm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] seed;
  q_stat_t     q_stat;
  logic        push;
  cmd_t        push_data;
  logic        pop;
  cmd_t        pop_data;
  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;

  // Seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'd0;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  mm3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  mm3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  mm3_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  mm3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed),
    .q_stat    (q_stat),
    .pop       (pop),
    .pop_data  (pop_data),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Checks
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into a full queue");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_stat.full)
    else $error("input stalled while the queue has room");

  a_mul_start: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

endmodule

// ===== bench/tb_murmur3_x64_128_hasher.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for murmur3_x64_128_hasher: streams whole messages of
// 16-byte blocks under several seeds and checks each 128-bit hash against a local model.
// Depends on mm3_pkg (transaction types) and the RTL of the hasher.
module tb_murmur3_x64_128_hasher;
  import mm3_pkg::*;

  // Hash constants, kept local so the model stands apart from the RTL
  localparam logic [63:0] KEY_MUL_A  = 64'h87c37b91114253d5;
  localparam logic [63:0] KEY_MUL_B  = 64'h4cf5ad432745937f;
  localparam logic [63:0] LANE_INC_A = 64'h0000000052dce729;
  localparam logic [63:0] LANE_INC_B = 64'h0000000038495ab5;
  localparam logic [63:0] FMIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam logic [31:0] BYTES_SAT  = 32'hFFFFFFFF;

  localparam int MAX_GAP        = 4;
  localparam int SETTLE_CYCLES  = 200;   // non-last blocks may still be mixing
  localparam int DRAIN_CYCLES   = 120;   // one block plus finalization, with margin
  localparam int LONG_HOLD      = 600;   // receiver hold-off to back up the input
  localparam int IDLE_LIMIT     = 5000;  // cycles with no transaction on either side
  localparam int PHASE_BLOCKS   = 110;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // Stimulus and expectations
  in_item_t  pending_blocks[$];
  out_item_t hash_expected[$];

  // Model state
  logic [31:0] seed_shadow = '0;
  logic [63:0] lane_a, lane_b;
  logic [31:0] msg_bytes;
  bit          msg_open = 1'b0;

  // Run control for the driver and the receiver
  bit no_gaps = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  int hold_left = 0;

  int fails = 0;
  int blocks_sent = 0;
  int messages_done = 0;
  int hashes_checked = 0;
  int seed_settings = 0;
  int idle_cycles = 0;

  murmur3_x64_128_hasher i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Hash model
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rotl64(input logic [63:0] v, input int s);
    return (v << s) | (v >> (64 - s));
  endfunction

  function automatic logic [63:0] fmix64(input logic [63:0] v);
    v = v ^ (v >> 33);
    v = v * FMIX_MUL_A;
    v = v ^ (v >> 33);
    v = v * FMIX_MUL_B;
    return v ^ (v >> 33);
  endfunction

  function automatic logic [63:0] scramble_k1(input logic [63:0] k);
    return rotl64(k * KEY_MUL_A, 31) * KEY_MUL_B;
  endfunction

  function automatic logic [63:0] scramble_k2(input logic [63:0] k);
    return rotl64(k * KEY_MUL_B, 33) * KEY_MUL_A;
  endfunction

  function automatic logic [63:0] keep_bytes(input logic [4:0] n);
    if (n >= 5'd8)
      return '1;
    return (64'h1 << (8 * n)) - 64'h1;
  endfunction

  // Absorb one accepted transaction; a last block queues the expected hash
  function automatic void absorb_block(input in_item_t t);
    logic [4:0]  n;
    logic [32:0] sum;
    logic [63:0] h1, h2;
    if (!msg_open) begin
      lane_a   = {32'h0, seed_shadow};
      lane_b   = {32'h0, seed_shadow};
      msg_bytes = '0;
      msg_open = 1'b1;
    end
    // non-last blocks always count as full; oversize counts saturate to 16
    if (!t.last_block || t.byte_count >= 5'd16)
      n = 5'd16;
    else
      n = t.byte_count;
    if (n == 5'd16) begin
      lane_a = lane_a ^ scramble_k1(t.block_low);
      lane_a = rotl64(lane_a, 27) + lane_b;
      lane_a = lane_a * 5 + LANE_INC_A;
      lane_b = lane_b ^ scramble_k2(t.block_high);
      lane_b = rotl64(lane_b, 31) + lane_a;
      lane_b = lane_b * 5 + LANE_INC_B;
    end else begin
      if (n > 5'd8)
        lane_b = lane_b ^ scramble_k2(t.block_high & keep_bytes(n - 5'd8));
      if (n > 5'd0)
        lane_a = lane_a ^ scramble_k1(t.block_low & keep_bytes(n));
    end
    sum = {1'b0, msg_bytes} + n;
    msg_bytes = sum[32] ? BYTES_SAT : sum[31:0];
    if (t.last_block) begin
      h1 = lane_a ^ {32'h0, msg_bytes};
      h2 = lane_b ^ {32'h0, msg_bytes};
      h1 = h1 + h2;
      h2 = h2 + h1;
      h1 = fmix64(h1);
      h2 = fmix64(h2);
      h1 = h1 + h2;
      h2 = h2 + h1;
      hash_expected.push_back('{hash_low: h1, hash_high: h2});
      msg_open = 1'b0;
      messages_done++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Block driver: one transaction per item, random gap drawn per item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_block(in_data);
        blocks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          in_data  <= pending_blocks.pop_front();
          in_valid <= 1'b1;
          tx_gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Hash receiver and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : hash_check
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      hold_left = 0;
      hold_seen = hold_req;
    end else begin
      if (out_valid && !out_stall) begin
        if (hash_expected.size() == 0) begin
          $error("hash result with nothing expected: %h", out_data);
          fails++;
        end else begin
          want = hash_expected.pop_front();
          if (out_data.hash_low !== want.hash_low) begin
            $error("hash_low: expected %h, actual %h", want.hash_low, out_data.hash_low);
            fails++;
          end
          if (out_data.hash_high !== want.hash_high) begin
            $error("hash_high: expected %h, actual %h", want.hash_high, out_data.hash_high);
            fails++;
          end
          hashes_checked++;
        end
        rx_wait = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      // long hold-off, counted here once requested
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (rx_wait > 0) || (hold_left > 0);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("murmur3_x64_128_hasher regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly legal tail sizes, with some oversize counts
  function automatic logic [4:0] rand_tail();
    int r;
    r = $urandom_range(0, 19);
    if (r <= 16)
      return r[4:0];
    return 5'($urandom_range(17, 31));
  endfunction

  task automatic push_block(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] n, input bit last);
    pending_blocks.push_back('{block_low: lo, block_high: hi, byte_count: n, last_block: last});
  endtask

  // Message of random content; byte_count on non-last blocks is noise
  task automatic push_message(input int blocks, input logic [4:0] tail_n);
    for (int i = 0; i < blocks - 1; i++)
      push_block(rand_word(), rand_word(), 5'($urandom_range(0, 31)), 1'b0);
    push_block(rand_word(), rand_word(), tail_n, 1'b1);
  endtask

  // Sampled between edges so driver updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_blocks.size() != 0 || in_valid || hash_expected.size() != 0)
      @(negedge clk);
  endtask

  // Seed write only once the hasher has gone quiet
  task automatic write_seed(input logic [31:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    seed_shadow = value;
    cfg_we <= 1'b0;
    seed_settings++;
  endtask

  task automatic random_phase(input logic [31:0] seed, input bit burst, input bit hold);
    int queued;
    queued = 0;
    write_seed(seed);
    no_gaps <= burst;
    if (hold)
      hold_req <= hold_req + 1;
    while (queued < PHASE_BLOCKS) begin
      int blocks;
      blocks = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      push_message(blocks, rand_tail());
      queued += blocks;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset seed, tail sizes at every boundary
    push_block('0, '0, 5'd0, 1'b1);                 // empty message
    push_block('1, '1, 5'd16, 1'b1);                // full last block
    push_block('1, '1, 5'd1, 1'b1);                 // single byte, rest masked
    push_block(64'h0706050403020100, '1, 5'd8, 1'b1); // k1 only, k2 untouched
    push_block('1, '1, 5'd9, 1'b1);                 // first byte of k2
    push_block(rand_word(), '1, 5'd15, 1'b1);
    push_block(rand_word(), rand_word(), 5'd31, 1'b1); // oversize count
    push_block(rand_word(), rand_word(), 5'd3, 1'b0);  // ignored count
    push_block(rand_word(), rand_word(), 5'd16, 1'b1);
    push_message(3, 5'd5);
    push_message(2, 5'd0);

    // Seed changed mid-message applies from the next message on
    push_block(rand_word(), rand_word(), 5'd16, 1'b0);
    write_seed(32'hFFFFFFFF);
    push_block(rand_word(), rand_word(), 5'd12, 1'b1);
    push_block('0, '0, 5'd0, 1'b1);
    push_block('1, '1, 5'd16, 1'b1);
    push_message(2, 5'd7);

    // Random messages under several seeds
    random_phase($urandom, 1'b0, 1'b1);
    random_phase(32'h0, 1'b1, 1'b0);
    random_phase(32'hFFFFFFFF, 1'b0, 1'b0);
    random_phase($urandom, 1'b0, 1'b1);
    random_phase($urandom, 1'b0, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (hash_expected.size() != 0) begin
      $error("hash_low/hash_high: expected %0d more hashes, actual 0",
             hash_expected.size());
      fails++;
    end

    $display("Sent %0d blocks forming %0d messages under %0d seed writes.",
             blocks_sent, messages_done, seed_settings);
    $display("Checked %0d hashes with random gaps, bursts and long receiver hold-offs.",
             hashes_checked);
    if (fails == 0)
      $display("murmur3_x64_128_hasher regression: pass");
    else
      $display("murmur3_x64_128_hasher regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mm3_pkg.sv
rtl/mm3_front.sv
rtl/mm3_queue.sv
rtl/mm3_mul.sv
rtl/mm3_back.sv
rtl/murmur3_x64_128_hasher.sv
bench/tb_murmur3_x64_128_hasher.sv
